// ===== design/dct_pkg.sv =====
// ----------------------------------------------------------------------------
// dct_pkg
// shared constants, types and the cosine basis function of the 8x8 dct block
// ----------------------------------------------------------------------------
package dct_pkg;

	// default fraction bits of the basis coefficients
	localparam int DCT_COEF_FRAC_BITS = 14;
	// default width of sample and result values
	localparam int DCT_VALUE_WIDTH = 12;
	// fraction bits of the high precision cosine table
	localparam int DCT_HI_FRAC = 30;

	// cos(m*pi/16), m = 0..8, with 30 fraction bits
	localparam int DCT_COS_HI [9] = '{
		1073741824, 1053110176, 992008094, 892783698, 759250125,
		596538995, 410903207, 209476638, 0
	};

	// sequencer phases
	typedef enum logic [3:0] {
		PH_LOAD  = 4'b0001,
		PH_ROW   = 4'b0010,
		PH_COL   = 4'b0100,
		PH_DRAIN = 4'b1000
	} dct_phase_t;

	// tag that travels with each product through the mac pipeline
	typedef struct packed {
		logic       col;
		logic       first;
		logic       last;
		logic [5:0] idx;
	} dct_tag_t;

	// basis coefficient alpha(k)*cos((2n+1)*k*pi/16), rounded to frac bits
	function automatic int dct_basis(input logic [2:0] k, input logic [2:0] n,
			input int frac);
		logic [6:0] prod;
		logic [4:0] mw;
		logic [3:0] mi;
		logic       neg;
		int         mag;
		prod = {3'b000, n, 1'b1} * {4'b0000, k};
		mw   = prod[4:0];
		neg  = 1'b0;
		// fold the angle into the first quadrant
		if (mw > 5'd16) begin
			mw = 5'd0 - mw;
		end
		if (mw > 5'd8) begin
			mw  = 5'd16 - mw;
			neg = 1'b1;
		end
		mi = mw[3:0];
		// dc row uses cos(pi/4)
		if (k == 3'd0) begin
			mi  = 4'd4;
			neg = 1'b0;
		end
		mag = (DCT_COS_HI[mi] + (1 << (DCT_HI_FRAC - frac - 1))) >>> (DCT_HI_FRAC - frac);
		return neg ? -mag : mag;
	endfunction

endpackage

// ===== design/dct_8x8_forward_inverse.sv =====
// ----------------------------------------------------------------------------
// dct_8x8_forward_inverse
// 8x8 forward dct (with level shift) or inverse dct on one shared mac unit
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  input    | sample_value                              | start && !busy
//  result   | result_value, result_index, block_last    | result_valid, 1 cycle
//  config   | cfg_wdata (inverse_mode)                  | cfg_we
//
//  loading takes one sample per cycle while start is held, 64 samples per block.
//  after the 64th sample the shared multiply-accumulate runs the row pass and
//  then the column pass (8 products per value); results leave one per column
//  sum, each through the coefficient, multiply, accumulate and scale registers.
//  busy stays high after the 64th sample and drops in the cycle the last result
//  is shown, so no new block can be loaded until then.
//  reset clears the sequencer, load count and mode; sample and row stores are not
//  cleared. results cannot be held off by the receiver.
//
module dct_8x8_forward_inverse #(
	parameter int COEF_FRAC_BITS = dct_pkg::DCT_COEF_FRAC_BITS,
	parameter int VALUE_WIDTH    = dct_pkg::DCT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic                          result_valid,
	output logic signed [VALUE_WIDTH-1:0] result_value,
	output logic [5:0]                    result_index,
	output logic                          block_last
);
	import dct_pkg::*;

	localparam int SW = VALUE_WIDTH + 1;
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int TW = SW + CW + 3;
	localparam int PW = TW + CW;
	localparam int AW = PW + 3;
	localparam int SH = 2 * COEF_FRAC_BITS + 2;

	localparam logic signed [TW-1:0] LVL_T  = TW'(128);
	localparam logic signed [AW-1:0] LVL_A  = AW'(128);
	localparam logic signed [AW-1:0] HALF   = AW'(1) << (SH - 1);
	localparam logic signed [AW-1:0] SAT_HI = AW'((2 ** (VALUE_WIDTH - 1)) - 1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

	dct_phase_t phase_q;
	logic [5:0] load_cnt_q;
	logic [8:0] seq_cnt_q;
	logic       inverse_mode_q;

	logic signed [VALUE_WIDTH-1:0] smp_mem_q [64];
	logic signed [TW-1:0]          row_mem_q [64];

	logic       accept;
	logic       issue;
	logic       col_pass;
	logic [2:0] hi, lo, tap;
	logic [5:0] rd_addr;
	logic [2:0] coef_k, coef_n;
	dct_tag_t   tag_s0;

	logic                          v_s1;
	dct_tag_t                      tag_s1;
	logic signed [CW-1:0]          coef_s1;
	logic signed [VALUE_WIDTH-1:0] smp_s1;
	logic signed [TW-1:0]          row_s1;

	logic signed [TW-1:0] mul_op;
	logic                 v_s2;
	dct_tag_t             tag_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [AW-1:0] sum;
	logic signed [AW-1:0] acc_q;
	logic                 row_we;
	logic                 fin_v_s3;
	logic [5:0]           fin_idx_s3;
	logic signed [AW-1:0] fin_s3;

	logic signed [AW-1:0] scaled;
	logic signed [AW-1:0] shifted;

	assign busy   = (phase_q != PH_LOAD);
	assign accept = start && !busy;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_mode_q <= 1'b0;
		end else if (cfg_we) begin
			inverse_mode_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LOAD;
			load_cnt_q <= 6'd0;
			seq_cnt_q  <= 9'd0;
		end else begin
			case (phase_q)
				PH_LOAD: begin
					if (accept) begin
						load_cnt_q <= load_cnt_q + 6'd1;
						if (&load_cnt_q) begin
							phase_q   <= PH_ROW;
							seq_cnt_q <= 9'd0;
						end
					end
				end
				PH_ROW: begin
					seq_cnt_q <= seq_cnt_q + 9'd1;
					if (&seq_cnt_q) begin
						phase_q <= PH_COL;
					end
				end
				PH_COL: begin
					seq_cnt_q <= seq_cnt_q + 9'd1;
					if (&seq_cnt_q) begin
						phase_q <= PH_DRAIN;
					end
				end
				PH_DRAIN: begin
					if (fin_v_s3 && (&fin_idx_s3)) begin
						phase_q <= PH_LOAD;
					end
				end
				default: begin
					phase_q <= PH_LOAD;
				end
			endcase
		end
	end

	// read address and basis indices for the current product
	always_comb begin
		issue    = (phase_q == PH_ROW) || (phase_q == PH_COL);
		col_pass = (phase_q == PH_COL);
		hi       = seq_cnt_q[8:6];
		lo       = seq_cnt_q[5:3];
		tap      = seq_cnt_q[2:0];
		if (col_pass) begin
			rd_addr = {tap, lo};
			coef_k  = hi;
		end else begin
			rd_addr = {hi, tap};
			coef_k  = lo;
		end
		coef_n = tap;
		// inverse transform uses the transposed basis
		if (inverse_mode_q) begin
			coef_k = tap;
			coef_n = col_pass ? hi : lo;
		end
		tag_s0.col   = col_pass;
		tag_s0.first = (tap == 3'd0);
		tag_s0.last  = (tap == 3'd7);
		tag_s0.idx   = seq_cnt_q[8:3];
	end

	// sample store: written during load, read in the row pass
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_mem_q[load_cnt_q] <= sample_value;
		end
		smp_s1 <= smp_mem_q[rd_addr];
	end

	// row pass store: written at the end of each row sum, read in the column pass
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem_q[tag_s2.idx] <= sum[TW-1:0];
		end
		row_s1 <= row_mem_q[rd_addr];
	end

	// stage 1: coefficient lookup and tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_s0;
		coef_s1 <= CW'(dct_basis(coef_k, coef_n, COEF_FRAC_BITS));
	end

	// stage 2: shared multiplier, forward row pass removes the level shift
	always_comb begin
		if (tag_s1.col) begin
			mul_op = row_s1;
		end else if (inverse_mode_q) begin
			mul_op = TW'(smp_s1);
		end else begin
			mul_op = TW'(smp_s1) - LVL_T;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= tag_s1;
		prod_s2 <= PW'(mul_op) * PW'(coef_s1);
	end

	// stage 3: accumulate, column sums start at the rounding half
	always_comb begin
		if (tag_s2.first) begin
			sum = (tag_s2.col ? HALF : '0) + AW'(prod_s2);
		end else begin
			sum = acc_q + AW'(prod_s2);
		end
		row_we = v_s2 && tag_s2.last && !tag_s2.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s3 <= 1'b0;
		end else begin
			fin_v_s3 <= v_s2 && tag_s2.last && tag_s2.col;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sum;
		end
		fin_s3     <= sum;
		fin_idx_s3 <= tag_s2.idx;
	end

	// stage 4: scale, level shift back for inverse, saturate
	always_comb begin
		scaled  = fin_s3 >>> SH;
		shifted = inverse_mode_q ? (scaled + LVL_A) : scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= fin_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (shifted > SAT_HI) begin
			result_value <= VALUE_WIDTH'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			result_value <= VALUE_WIDTH'(SAT_LO);
		end else begin
			result_value <= VALUE_WIDTH'(shifted);
		end
		result_index <= fin_idx_s3;
		block_last   <= &fin_idx_s3;
	end

`ifndef SYNTH
	// pipeline is empty whenever samples are being loaded
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOAD) |-> !(v_s1 || v_s2 || fin_v_s3))
		else $error("mac pipeline active during load");

	// results are never back to back, being spaced by the eight products of each sum
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back results");

	// the 64th sample starts the row pass
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (load_cnt_q == 6'd63)) |=> (phase_q == PH_ROW))
		else $error("full block did not start the transform");

	// the last result of a block frees the block for loading
	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && block_last) |-> (phase_q == PH_LOAD))
		else $error("busy after last result");
`endif

endmodule
